/* rtl/ipset_pkg.sv */
// Shared types and constants for the IP address set insert block.
// No dependencies; imported by every module of the block.
package ipset_pkg;

   localparam int DEFAULT_TABLE_SLOTS = 256;

   localparam logic [31:0] FNV_BASIS      = 32'h811C_9DC5;
   localparam logic [31:0] FNV_MULTIPLIER = 32'h0100_0193;

   localparam logic [1:0] FAMILY_V4 = 2'd0;
   localparam logic [1:0] FAMILY_V6 = 2'd1;

   // slot flag bits
   localparam int FLAG_OCC_BIT = 0;
   localparam int FLAG_V6_BIT  = 1;

   localparam int          CSR_ADDR_W        = 3;
   localparam logic        REG_MAX_ENTRIES   = 1'b0;
   localparam logic [7:0]  MAX_ENTRIES_RESET = 8'd192;

   typedef enum logic [1:0] {
      STATUS_ADDED   = 2'd0,
      STATUS_PRESENT = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_UNKNOWN = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  flags;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
   } entry_type;

endpackage

/* rtl/ip_address_set_insert_unit.sv */
// IP address set insert unit: keeps a set of IPv4/IPv6 addresses in a hashed slot table.
// req_ channel carries one address item (family_code, address_hi, address_lo); rsp_
// channel returns one item per request: status, slot_index, entry_count. Both use
// valid/ready. The csr_ APB port holds max_entries at byte address 0 (reset 192).
// Steps: byte-serial FNV-1a hashing of 4 (IPv4) or 16 (IPv6) address bytes, one byte per
// cycle through the multiplier, then a reciprocal remainder (multiply, quotient,
// remainder) when TABLE_SLOTS is not a power of two, then per probed slot a memory
// read, then compare and write back, then hand-off of the slot and loading of the
// output register. Unknown family items go straight to loading the output register.
// One item is in work at a time; the next is taken the cycle after its result is loaded.
// After reset the slot table is swept to empty, one slot a cycle; req_ready stays
// low meanwhile, configuration writes are taken as usual.
// A finished result sits in the output register; the next item may be accepted
// while it waits, and a further finished result waits inside until rsp_ready.
// Depends on ipset_pkg, ipset_hash and ipset_mem.
module ip_address_set_insert_unit
   import ipset_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_family_code,
   input  logic [63:0]           req_address_hi,
   input  logic [63:0]           req_address_lo,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_status,
   output logic [7:0]            rsp_slot_index,
   output logic [7:0]            rsp_entry_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [SLOT_W:0]   LAST_PROBE = (SLOT_W + 1)'(TABLE_SLOTS - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   state_type         state_ff;
   logic [SLOT_W-1:0] clr_ff;
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W:0]   probe_ff;
   logic              v6_ff;
   logic [63:0]       key_hi_ff;
   logic [63:0]       key_lo_ff;
   logic [7:0]        count_ff;
   logic [7:0]        max_ff;
   status_type        res_status_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [7:0]        rsp_slot_ff;
   logic [7:0]        rsp_count_ff;

   logic              req_fire;
   logic              req_known;
   logic              hash_done;
   logic [SLOT_W-1:0] hash_slot;
   logic              mem_wr_en;
   logic [SLOT_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;
   logic              mem_rd_en;
   entry_type         mem_rd_data;
   logic [1:0]        want_flags;
   logic              slot_empty;
   logic              slot_match;
   logic              insert_ok;
   logic              csr_write;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_known = (req_family_code == FAMILY_V4) || (req_family_code == FAMILY_V6);

   ipset_hash #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (req_fire && req_known),
      .is_v6 (req_family_code == FAMILY_V6),
      .key_hi(req_address_hi),
      .key_lo(req_address_lo),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   always_comb begin
      want_flags               = '0;
      want_flags[FLAG_OCC_BIT] = 1'b1;
      want_flags[FLAG_V6_BIT]  = v6_ff;
      slot_empty = !mem_rd_data.flags[FLAG_OCC_BIT];
      slot_match = (mem_rd_data.flags == want_flags) && (mem_rd_data.key_hi == key_hi_ff)
                   && (mem_rd_data.key_lo == key_lo_ff);
      insert_ok  = slot_empty && (count_ff < max_ff);
   end

   always_comb begin
      mem_rd_en   = (state_ff == S_READ);
      mem_wr_en   = (state_ff == S_CLEAR) || ((state_ff == S_CHECK) && insert_ok);
      mem_wr_addr = (state_ff == S_CLEAR) ? clr_ff : idx_ff;
      mem_wr_data = '0;
      if (state_ff != S_CLEAR) begin
         mem_wr_data.flags  = want_flags;
         mem_wr_data.key_hi = key_hi_ff;
         mem_wr_data.key_lo = key_lo_ff;
      end
   end

   ipset_mem #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(idx_ff),
      .rd_data(mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_SLOT) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  v6_ff     <= (req_family_code == FAMILY_V6);
                  key_hi_ff <= (req_family_code == FAMILY_V6) ? req_address_hi : 64'd0;
                  key_lo_ff <= (req_family_code == FAMILY_V6) ? req_address_lo
                                                               : {32'd0, req_address_lo[31:0]};
                  if (req_known) begin
                     state_ff <= S_HASH;
                  end else begin
                     res_status_ff <= STATUS_UNKNOWN;
                     res_slot_ff   <= '0;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_HASH: begin
               if (hash_done) begin
                  idx_ff   <= hash_slot;
                  probe_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               priority if (slot_empty) begin
                  if (insert_ok) begin
                     count_ff      <= count_ff + 8'd1;
                     res_status_ff <= STATUS_ADDED;
                     res_slot_ff   <= idx_ff;
                  end else begin
                     res_status_ff <= STATUS_FULL;
                     res_slot_ff   <= '0;
                  end
                  state_ff <= S_DONE;
               end else if (slot_match) begin
                  res_status_ff <= STATUS_PRESENT;
                  res_slot_ff   <= idx_ff;
                  state_ff      <= S_DONE;
               end else if (probe_ff == LAST_PROBE) begin
                  // every slot occupied and none matches
                  res_status_ff <= STATUS_FULL;
                  res_slot_ff   <= '0;
                  state_ff      <= S_DONE;
               end else begin
                  idx_ff   <= (idx_ff == LAST_SLOT) ? '0 : idx_ff + 1'b1;
                  probe_ff <= probe_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_slot_ff   <= 8'(res_slot_ff);
                  rsp_count_ff  <= count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_entry_count = rsp_count_ff;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_ENTRIES_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_MAX_ENTRIES)) begin
         max_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MAX_ENTRIES) ? {24'd0, max_ff} : 32'd0;

   // count moves only upward, one step at a time
   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + 8'd1))
      else $error("stored count changed by other than one");

   // refused and unknown items carry slot zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == STATUS_FULL) || (rsp_status == STATUS_UNKNOWN)))
      |-> (rsp_slot_index == 8'd0))
      else $error("error result with nonzero slot");

   // a new item is never taken while a probe read is in flight
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mem_rd_en && !mem_wr_en)
      else $error("table access while idle");

   // an added result means the count grew when it was produced
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CHECK) && slot_empty && insert_ok) |=> (count_ff != $past(count_ff)))
      else $error("insert without count update");

endmodule

/* rtl/ipset_hash.sv */
// Byte-serial FNV-1a hash unit with home slot reduction (mask or reciprocal remainder).
// Depends on ipset_pkg.
module ipset_hash
   import ipset_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS,
   localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              is_v6,
   input  logic [63:0]       key_hi,
   input  logic [63:0]       key_lo,
   output logic              done,
   output logic [SLOT_W-1:0] slot
);

   localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
   // 2^(32+SLOT_W) / TABLE_SLOTS rounded up; bit 32 is always set, so only the
   // low word goes through the multiplier
   localparam logic [63:0] RECIP      = ((64'd1 << (32 + SLOT_W)) / 64'(TABLE_SLOTS)) + 64'd1;
   localparam logic [31:0] RECIP_LO   = RECIP[31:0];
   localparam logic [31:0] SLOTS_WORD = 32'(TABLE_SLOTS);

   typedef enum logic [2:0] {
      H_IDLE,
      H_BYTES,
      H_MUL,
      H_QUO,
      H_REM
   } hstate_type;

   hstate_type        state_ff;
   logic [127:0]      shift_ff;
   logic [31:0]       hash_ff;
   logic [4:0]        count_ff;
   logic [63:0]       prod_ff;
   logic [31:0]       quo_ff;
   logic              done_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [31:0]       hash_in;
   logic [63:0]       prod_in;
   logic [32:0]       quo_sum;
   logic [31:0]       quo_in;
   logic [31:0]       rem_in;

   always_comb begin
      hash_in = (hash_ff ^ {24'd0, shift_ff[127:120]}) * FNV_MULTIPLIER;
      prod_in = 64'(hash_ff) * 64'(RECIP_LO);
      quo_sum = {1'b0, hash_ff} + {1'b0, prod_ff[63:32]};
      quo_in  = 32'(quo_sum >> SLOT_W);
      rem_in  = hash_ff - quo_ff * SLOTS_WORD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            H_IDLE: begin
               if (start) begin
                  hash_ff  <= FNV_BASIS;
                  shift_ff <= is_v6 ? {key_hi, key_lo} : {key_lo[31:0], 96'd0};
                  count_ff <= is_v6 ? 5'd16 : 5'd4;
                  state_ff <= H_BYTES;
               end
            end
            H_BYTES: begin
               hash_ff  <= hash_in;
               shift_ff <= shift_ff << 8;
               count_ff <= count_ff - 5'd1;
               if (count_ff == 5'd1) begin
                  if (IS_POW2) begin
                     slot_ff  <= hash_in[SLOT_W-1:0];
                     done_ff  <= 1'b1;
                     state_ff <= H_IDLE;
                  end else begin
                     state_ff <= H_MUL;
                  end
               end
            end
            H_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= H_QUO;
            end
            H_QUO: begin
               quo_ff   <= quo_in;
               state_ff <= H_REM;
            end
            H_REM: begin
               slot_ff  <= rem_in[SLOT_W-1:0];
               done_ff  <= 1'b1;
               state_ff <= H_IDLE;
            end
            default: state_ff <= H_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign slot = slot_ff;

endmodule

/* rtl/ipset_mem.sv */
// Slot table memory: one write port, one read port with registered read data.
// Depends on ipset_pkg for the entry layout.
module ipset_mem
   import ipset_pkg::*;
#(
   parameter int TABLE_SLOTS = DEFAULT_TABLE_SLOTS,
   localparam int SLOT_W = $clog2(TABLE_SLOTS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem_ff [TABLE_SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/ip_address_set_insert_unit_test.sv */
// Self-checking testbench for ip_address_set_insert_unit: a directed table and then
// random address traffic, checked item by item against a hash-set predictor.
// Depends on ipset_pkg and the RTL of the block; needs nothing else.
module ip_address_set_insert_unit_test;
   import ipset_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = DEFAULT_TABLE_SLOTS;
   localparam logic [1:0] FAMILY_UNKNOWN  = 2'd2;
   localparam logic [1:0] FAMILY_RESERVED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] LIMIT_ADDR = CSR_ADDR_W'(4 * int'(REG_MAX_ENTRIES));
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 198;

   typedef struct packed {
      logic [1:0]  family;
      logic [63:0] hi;
      logic [63:0] lo;
   } address_item;

   typedef struct packed {
      status_type  status;
      logic [7:0]  slot;
      logic [7:0]  count;
   } set_result;

   typedef struct packed {
      bit          set_limit;   // row programs max_entries instead of sending an item
      logic [7:0]  limit;
      address_item addr;
      bit          typed;       // result below is fixed, not taken from the predictor
      set_result   want;
   } directed_row;

   localparam address_item NO_ADDRESS = '0;
   localparam set_result   PREDICTED  = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_family_code = '0;
   logic [63:0]           req_address_hi = '0;
   logic [63:0]           req_address_lo = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_status;
   logic [7:0]            rsp_slot_index;
   logic [7:0]            rsp_entry_count;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   ip_address_set_insert_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_family_code(req_family_code),
      .req_address_hi (req_address_hi),
      .req_address_lo (req_address_lo),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_entry_count(rsp_entry_count),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the slot table
   logic [63:0] shadow_key_hi [SLOTS];
   logic [63:0] shadow_key_lo [SLOTS];
   logic [1:0]  shadow_flags  [SLOTS];
   logic [7:0]  shadow_count = '0;
   logic [7:0]  shadow_limit = MAX_ENTRIES_RESET;

   set_result   pending_results [$];
   address_item known_addresses [$];
   int          failures = 0;
   int          status_seen [4] = '{0, 0, 0, 0};
   int          limit_writes = 0;
   bit          sender_steady = 1'b0;
   set_result   oldest;

   // Directed part. Counts in typed rows follow from the adds above them:
   // rows 1-6 store five keys (row 5 hits the first one), rows 9-10 two more.
   directed_row directed_rows [20] = '{
      '{1'b0, 8'd0, '{FAMILY_V4, 64'h0, 64'h0}, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V4, {64{1'b1}}, {64{1'b1}}}, 1'b0, PREDICTED},
      // same key bits as the first IPv4 key, other family
      '{1'b0, 8'd0, '{FAMILY_V6, 64'h0, 64'h0}, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V6, {64{1'b1}}, {64{1'b1}}}, 1'b0, PREDICTED},
      // IPv4 with junk in the ignored bits: hits the zero address
      '{1'b0, 8'd0, '{FAMILY_V4, 64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF_0000_0000},
        1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V6, 64'h0, 64'h0000_0000_FFFF_FFFF}, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_UNKNOWN, 64'h0, 64'h0}, 1'b1,
        '{STATUS_UNKNOWN, 8'd0, 8'd5}},
      '{1'b0, 8'd0, '{FAMILY_RESERVED, {64{1'b1}}, {64{1'b1}}}, 1'b1,
        '{STATUS_UNKNOWN, 8'd0, 8'd5}},
      '{1'b0, 8'd0, '{FAMILY_V6, 64'h8000_0000_0000_0000, 64'h0}, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V4, 64'h0, 64'h0000_0000_8000_0000}, 1'b0, PREDICTED},
      // limit zero: new keys refused, known keys still found
      '{1'b1, 8'd0, NO_ADDRESS, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V4, 64'h0, 64'h0000_0000_0A00_0001}, 1'b1,
        '{STATUS_FULL, 8'd0, 8'd7}},
      '{1'b0, 8'd0, '{FAMILY_V4, 64'h0, 64'h0}, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V6, 64'h2001_0DB8_0000_0000, 64'h1}, 1'b1,
        '{STATUS_FULL, 8'd0, 8'd7}},
      // room for exactly one more
      '{1'b1, 8'd8, NO_ADDRESS, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V4, 64'h0, 64'h0000_0000_C0A8_0001}, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_V4, 64'h0, 64'h0000_0000_C0A8_0002}, 1'b1,
        '{STATUS_FULL, 8'd0, 8'd8}},
      '{1'b0, 8'd0, '{FAMILY_V6, {64{1'b1}}, {64{1'b1}}}, 1'b0, PREDICTED},
      '{1'b1, 8'd255, NO_ADDRESS, 1'b0, PREDICTED},
      '{1'b0, 8'd0, '{FAMILY_RESERVED, 64'h0, 64'h0}, 1'b1,
        '{STATUS_UNKNOWN, 8'd0, 8'd8}}
   };

   function automatic logic [31:0] fnv1a_hash(input address_item a);
      logic [31:0]  h;
      logic [127:0] bytes_be;
      int           n;
      h = FNV_BASIS;
      if (a.family == FAMILY_V6) begin
         bytes_be = {a.hi, a.lo};
         n = 16;
      end else begin
         bytes_be = {96'b0, a.lo[31:0]};
         n = 4;
      end
      for (int i = n - 1; i >= 0; i--) begin
         h = (h ^ {24'b0, bytes_be[8*i +: 8]}) * FNV_MULTIPLIER;
      end
      return h;
   endfunction

   // Runs one item through the shadow table and returns its result.
   function automatic set_result insert_address(input address_item a);
      set_result   r;
      logic [63:0] khi;
      logic [63:0] klo;
      logic [1:0]  want_flags;
      int          idx;
      bit          hit;
      bit          hole;
      r = '{STATUS_UNKNOWN, 8'd0, shadow_count};
      if (a.family != FAMILY_V4 && a.family != FAMILY_V6) begin
         return r;
      end
      want_flags = '0;
      want_flags[FLAG_OCC_BIT] = 1'b1;
      if (a.family == FAMILY_V6) begin
         khi = a.hi;
         klo = a.lo;
         want_flags[FLAG_V6_BIT] = 1'b1;
      end else begin
         khi = '0;
         klo = {32'b0, a.lo[31:0]};
      end
      idx = int'(fnv1a_hash(a) % SLOTS);
      hit = 1'b0;
      hole = 1'b0;
      for (int n = 0; n < SLOTS; n++) begin
         if (!shadow_flags[idx][FLAG_OCC_BIT]) begin
            hole = 1'b1;
            break;
         end
         if (shadow_flags[idx] == want_flags && shadow_key_hi[idx] == khi &&
             shadow_key_lo[idx] == klo) begin
            hit = 1'b1;
            break;
         end
         idx = (idx + 1) % SLOTS;
      end
      if (hit) begin
         r.status = STATUS_PRESENT;
         r.slot = idx[7:0];
      end else if (!hole || shadow_count >= shadow_limit) begin
         r.status = STATUS_FULL;
      end else begin
         shadow_key_hi[idx] = khi;
         shadow_key_lo[idx] = klo;
         shadow_flags[idx] = want_flags;
         shadow_count = shadow_count + 8'd1;
         r.status = STATUS_ADDED;
         r.slot = idx[7:0];
      end
      r.count = shadow_count;
      return r;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   function automatic address_item random_address();
      address_item a;
      address_item old;
      int          roll;
      roll = $urandom_range(0, 99);
      a.family = ($urandom_range(0, 1) != 0) ? FAMILY_V6 : FAMILY_V4;
      a.hi = {$urandom, $urandom};
      a.lo = {$urandom, $urandom};
      if (roll < 8) begin
         a.family = ($urandom_range(0, 1) != 0) ? FAMILY_UNKNOWN : FAMILY_RESERVED;
      end else if (roll < 45 && known_addresses.size() != 0) begin
         old = known_addresses[$urandom_range(0, known_addresses.size() - 1)];
         if (roll < 36) begin
            // repeat of a stored key; IPv4 keeps random junk in the ignored bits
            a.family = old.family;
            a.lo[31:0] = old.lo[31:0];
            if (old.family == FAMILY_V6) begin
               a.hi = old.hi;
               a.lo = old.lo;
            end
         end else if (old.family == FAMILY_V4) begin
            // same key bits under the other family
            a.family = FAMILY_V6;
            a.hi = '0;
            a.lo = {32'b0, old.lo[31:0]};
         end else begin
            a.family = FAMILY_V4;
            a.lo[31:0] = old.lo[31:0];
         end
      end
      return a;
   endfunction

   task automatic send_address(input address_item a, input bit typed, input set_result fixed);
      set_result predicted;
      int        gap;
      req_valid <= 1'b1;
      req_family_code <= a.family;
      req_address_hi <= a.hi;
      req_address_lo <= a.lo;
      do @(posedge clock); while (!req_ready);
      predicted = insert_address(a);
      if (predicted.status == STATUS_ADDED) known_addresses.push_back(a);
      pending_results.push_back(typed ? fixed : predicted);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic finish_outstanding();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // write, then read back
   task automatic program_max_entries(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= {24'b0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow_limit = value;
      limit_writes++;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {24'b0, value}) begin
         $error("max_entries readback: expected %0d, got %0d", value, csr_prdata);
         failures++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected: status %0d slot %0d count %0d",
                   rsp_status, rsp_slot_index, rsp_entry_count);
            failures++;
         end else begin
            oldest = pending_results.pop_front();
            status_seen[rsp_status]++;
            if (rsp_status !== oldest.status) begin
               $error("status: expected %0d, got %0d", oldest.status, rsp_status);
               failures++;
            end
            if (rsp_slot_index !== oldest.slot) begin
               $error("slot_index: expected %0d, got %0d", oldest.slot, rsp_slot_index);
               failures++;
            end
            if (rsp_entry_count !== oldest.count) begin
               $error("entry_count: expected %0d, got %0d", oldest.count, rsp_entry_count);
               failures++;
            end
         end
      end
   end

   // result side back-pressure; now and then a long run with ready held high
   initial begin
      int run;
      int stall;
      forever begin
         rsp_ready <= 1'b1;
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      logic [7:0] phase_limit [PHASES];
      phase_limit = '{8'd40, 8'd0, 8'd120, 8'd1, 8'd200, 8'd255,
                      8'($urandom_range(1, 255)), 8'd255};
      for (int s = 0; s < SLOTS; s++) begin
         shadow_key_hi[s] = '0;
         shadow_key_lo[s] = '0;
         shadow_flags[s] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].set_limit) begin
            finish_outstanding();
            program_max_entries(directed_rows[r].limit);
         end else begin
            send_address(directed_rows[r].addr, directed_rows[r].typed, directed_rows[r].want);
         end
      end

      // each phase starts from an empty pipeline with a new limit
      for (int p = 0; p < PHASES; p++) begin
         finish_outstanding();
         program_max_entries(phase_limit[p]);
         sender_steady = (p == 2);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            send_address(random_address(), 1'b0, PREDICTED);
         end
      end
      finish_outstanding();
      repeat (40) @(posedge clock);

      $display("checked %0d added, %0d present, %0d refused, %0d unknown-family items",
               status_seen[STATUS_ADDED], status_seen[STATUS_PRESENT],
               status_seen[STATUS_FULL], status_seen[STATUS_UNKNOWN]);
      $display("across %0d max_entries settings, %0d keys stored at the end",
               limit_writes, shadow_count);
      if (failures == 0) begin
         $display("ip_address_set_insert_unit verification clean");
      end else begin
         $display("ip_address_set_insert_unit verification failed");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("ip_address_set_insert_unit verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ipset_pkg.sv
rtl/ipset_hash.sv
rtl/ipset_mem.sv
rtl/ip_address_set_insert_unit.sv
tb/ip_address_set_insert_unit_test.sv
